// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

  localparam int unsigned MS_W      = 16;
  localparam int unsigned ELAPSED_W = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX     = 3'd4;

  // reset values
  localparam logic [MS_W-1:0]    RST_LONG_PRESS    = 16'd3000;
  localparam logic [MS_W-1:0]    RST_LONG_MID      = 16'd5000;
  localparam logic [MS_W-1:0]    RST_LONG_MAX      = 16'd10000;
  localparam logic [MS_W-1:0]    RST_REPEAT_WINDOW = 16'd500;
  localparam logic [COUNT_W-1:0] RST_SHORT_MAX     = 4'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_SHORT  = 2'd0;
  localparam logic [KIND_W-1:0] EV_LONG_1 = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG_2 = 2'd2;
  localparam logic [KIND_W-1:0] EV_LONG_3 = 2'd3;

  typedef struct packed {
    logic [MS_W-1:0]    long_press_ms;
    logic [MS_W-1:0]    long_mid_ms;
    logic [MS_W-1:0]    long_max_ms;
    logic [MS_W-1:0]    repeat_window_ms;
    logic [COUNT_W-1:0] short_press_max;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [KIND_W-1:0]  event_kind;
    logic [COUNT_W-1:0] press_count;
  } result_t;

endpackage

// ===== rtl/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bpc_pkg::CFG_DAT_W-1:0]    cfg_wr_data,
  output bpc_pkg::cfg_t                    cfg
);

  bpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms    <= bpc_pkg::RST_LONG_PRESS;
      cfg_r.long_mid_ms      <= bpc_pkg::RST_LONG_MID;
      cfg_r.long_max_ms      <= bpc_pkg::RST_LONG_MAX;
      cfg_r.repeat_window_ms <= bpc_pkg::RST_REPEAT_WINDOW;
      cfg_r.short_press_max  <= bpc_pkg::RST_SHORT_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        bpc_pkg::REG_LONG_PRESS:    cfg_r.long_press_ms    <= cfg_wr_data;
        bpc_pkg::REG_LONG_MID:      cfg_r.long_mid_ms      <= cfg_wr_data;
        bpc_pkg::REG_LONG_MAX:      cfg_r.long_max_ms      <= cfg_wr_data;
        bpc_pkg::REG_REPEAT_WINDOW: cfg_r.repeat_window_ms <= cfg_wr_data;
        bpc_pkg::REG_SHORT_MAX:
          cfg_r.short_press_max <= cfg_wr_data[bpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bpc_core.sv =====
module bpc_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic                              pin_level,
  input  logic [bpc_pkg::ELAPSED_W-1:0]     elapsed_ms,
  input  bpc_pkg::cfg_t                     cfg,
  output bpc_pkg::result_t                  res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRESS_DB = 3'd1;
  localparam logic [2:0] PH_HELD     = 3'd2;
  localparam logic [2:0] PH_REL_DB   = 3'd3;
  localparam logic [2:0] PH_REPEAT   = 3'd4;

  logic [2:0]                  phase_r, phase_nxt;
  logic [bpc_pkg::MS_W-1:0]    since_r, since_nxt;
  logic [bpc_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic                        pressed;
  logic [bpc_pkg::MS_W:0]      sum;
  logic [bpc_pkg::MS_W-1:0]    stamp;
  logic [bpc_pkg::COUNT_W-1:0] count_inc;

  assign pressed   = ~pin_level;
  assign sum       = {1'b0, since_r} + {{(bpc_pkg::MS_W + 1 - bpc_pkg::ELAPSED_W){1'b0}},
                                        elapsed_ms};
  // saturate at full scale
  assign stamp     = sum[bpc_pkg::MS_W] ? {bpc_pkg::MS_W{1'b1}} : sum[bpc_pkg::MS_W-1:0];
  assign count_inc = count_r + 4'd1;

  always_comb begin
    phase_nxt       = phase_r;
    since_nxt       = stamp;
    count_nxt       = count_r;
    res.emit        = 1'b0;
    res.event_kind  = bpc_pkg::EV_SHORT;
    res.press_count = '0;
    case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          since_nxt = '0;
          phase_nxt = PH_PRESS_DB;
        end
      end
      PH_PRESS_DB: begin
        phase_nxt = pressed ? PH_HELD : PH_IDLE;
      end
      PH_HELD: begin
        if (!pressed) phase_nxt = PH_REL_DB;
      end
      PH_REL_DB: begin
        if (pressed) begin
          phase_nxt = PH_HELD;
        end else begin
          since_nxt = '0;
          if (stamp >= cfg.long_press_ms) begin
            // long press mid-run drops the run silently
            phase_nxt = PH_IDLE;
            count_nxt = '0;
            if (count_r == '0) begin
              res.emit = 1'b1;
              if (stamp >= cfg.long_max_ms)      res.event_kind = bpc_pkg::EV_LONG_3;
              else if (stamp >= cfg.long_mid_ms) res.event_kind = bpc_pkg::EV_LONG_2;
              else                               res.event_kind = bpc_pkg::EV_LONG_1;
            end
          end else if (count_inc >= cfg.short_press_max) begin
            res.emit        = 1'b1;
            res.press_count = count_inc;
            phase_nxt       = PH_IDLE;
            count_nxt       = '0;
          end else begin
            count_nxt = count_inc;
            phase_nxt = PH_REPEAT;
          end
        end
      end
      PH_REPEAT: begin
        if (pressed) begin
          phase_nxt = PH_PRESS_DB;
        end else if (stamp >= cfg.repeat_window_ms) begin
          res.emit        = 1'b1;
          res.press_count = count_r;
          phase_nxt       = PH_IDLE;
          count_nxt       = '0;
          since_nxt       = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        count_nxt = '0;
        since_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      since_r <= '0;
      count_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      since_r <= since_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/button_press_classifier_unit.sv =====
// channel | dir | ports                                    | word
// in      | in  | in_valid, in_stall(out)                  | in_pin_level, in_elapsed_ms
// out     | out | out_valid, out_stall(in)                 | out_event_kind, out_press_count
// cfg     | in  | cfg_wr_en, cfg_idx                       | cfg_wr_data
//
// One word per cycle sustained while no held result stalls the output. A word
// lands in the input register, is stepped through the classifier once the output
// register is free, and any result is registered there and raises out_valid.
// rst_n is synchronous; it clears state, valids and config to defaults.
// A stalled output holds the word; the input register keeps accepting until
// it is itself full behind a held result.
module button_press_classifier_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_pin_level,
  input  logic [bpc_pkg::ELAPSED_W-1:0]    in_elapsed_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpc_pkg::KIND_W-1:0]       out_event_kind,
  output logic [bpc_pkg::COUNT_W-1:0]      out_press_count,
  input  logic                             cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bpc_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::result_t res;

  logic                           s1_valid_r;
  logic                           s1_pin_r;
  logic [bpc_pkg::ELAPSED_W-1:0]  s1_elapsed_r;
  logic                           s1_move;
  logic                           in_accept;
  logic                           out_valid_r, out_valid_nxt;
  logic [bpc_pkg::KIND_W-1:0]     out_kind_r;
  logic [bpc_pkg::COUNT_W-1:0]    out_count_r;

  // stage 1 may step when the output register will be free
  assign s1_move   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  bpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_idx     (cfg_idx),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  bpc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_move),
    .pin_level  (s1_pin_r),
    .elapsed_ms (s1_elapsed_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_comb begin
    if (s1_move && res.emit) out_valid_nxt = 1'b1;
    else                     out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept || (s1_valid_r && !s1_move);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pin_r     <= in_pin_level;
      s1_elapsed_r <= in_elapsed_ms;
    end
    if (s1_move && res.emit) begin
      out_kind_r  <= res.event_kind;
      out_count_r <= res.press_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_press_count = out_count_r;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int LIMIT_CYCLES    = 100000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_WORDS     = 28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS_CHK,
    ST_HELD,
    ST_REL_CHK,
    ST_REPEAT
  } btn_state_t;

  typedef struct packed {
    logic                 pin;
    logic [ELAPSED_W-1:0] dt;
  } pin_sample_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } press_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_pin_level = 1'b1;
  logic [ELAPSED_W-1:0] in_elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_event_kind;
  logic [COUNT_W-1:0]   out_press_count;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_wr_data = '0;

  // classifier shadow: state and register copies
  btn_state_t         btn_state;
  logic [MS_W-1:0]    since_ms;
  logic [COUNT_W-1:0] run_count;
  logic [MS_W-1:0]    long_ms;
  logic [MS_W-1:0]    mid_ms;
  logic [MS_W-1:0]    max_ms;
  logic [MS_W-1:0]    window_ms;
  logic [COUNT_W-1:0] max_presses;

  pin_sample_t  sample_q[$];
  press_event_t event_q[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int added         = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_go       = 1'b0;
  bit hold_done     = 1'b0;
  bit word_taken    = 1'b0;

  button_press_classifier_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pin_level    (in_pin_level),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_press_count (out_press_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_idx         (cfg_idx),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_run();
    btn_state = ST_IDLE;
    run_count = '0;
    since_ms  = '0;
  endfunction

  function automatic void post_event(input logic [KIND_W-1:0] kind,
                                     input logic [COUNT_W-1:0] count);
    press_event_t ev;
    ev.kind  = kind;
    ev.count = count;
    event_q.push_back(ev);
  endfunction

  task automatic classify_sample(input pin_sample_t s);
    logic [MS_W:0]   sum;
    logic [MS_W-1:0] hold;
    logic            pressed;
    pressed  = ~s.pin;
    sum      = {1'b0, since_ms} + {{(MS_W + 1 - ELAPSED_W){1'b0}}, s.dt};
    since_ms = sum[MS_W] ? '1 : sum[MS_W-1:0];
    case (btn_state)
      ST_IDLE: begin
        if (pressed) begin
          since_ms  = '0;
          btn_state = ST_PRESS_CHK;
        end
      end
      ST_PRESS_CHK: btn_state = pressed ? ST_HELD : ST_IDLE;
      ST_HELD: begin
        if (!pressed) btn_state = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (pressed) begin
          btn_state = ST_HELD;
        end else begin
          hold     = since_ms;
          since_ms = '0;
          if (hold >= long_ms) begin
            // a long press in the middle of a run is dropped silently
            if (run_count == '0)
              post_event(hold >= max_ms ? EV_LONG_3 : (hold >= mid_ms ? EV_LONG_2 : EV_LONG_1),
                         '0);
            clear_run();
          end else begin
            run_count = run_count + 4'd1;
            if (run_count >= max_presses) begin
              post_event(EV_SHORT, run_count);
              clear_run();
            end else begin
              btn_state = ST_REPEAT;
            end
          end
        end
      end
      ST_REPEAT: begin
        if (pressed) begin
          btn_state = ST_PRESS_CHK;
        end else if (since_ms >= window_ms) begin
          post_event(EV_SHORT, run_count);
          clear_run();
        end
      end
      default: clear_run();
    endcase
  endtask

  always @(posedge clk) begin : monitor
    press_event_t want;
    if (!rst_n) begin
      long_ms     = RST_LONG_PRESS;
      mid_ms      = RST_LONG_MID;
      max_ms      = RST_LONG_MAX;
      window_ms   = RST_REPEAT_WINDOW;
      max_presses = RST_SHORT_MAX;
      clear_run();
      word_taken = 1'b0;
    end else begin
      word_taken = in_valid && !in_stall;
      if (word_taken) classify_sample({in_pin_level, in_elapsed_ms});
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_LONG_PRESS:    long_ms     = cfg_wr_data;
          REG_LONG_MID:      mid_ms      = cfg_wr_data;
          REG_LONG_MAX:      max_ms      = cfg_wr_data;
          REG_REPEAT_WINDOW: window_ms   = cfg_wr_data;
          REG_SHORT_MAX:     max_presses = cfg_wr_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          flag_error($sformatf("unexpected word kind %0d count %0d",
                               out_event_kind, out_press_count));
        end else begin
          want = event_q.pop_front();
          if (out_event_kind !== want.kind)
            flag_error($sformatf("event_kind %0d, want %0d", out_event_kind, want.kind));
          if (out_press_count !== want.count)
            flag_error($sformatf("press_count %0d, want %0d", out_press_count, want.count));
        end
      end
    end
  end

  // sender: hold the word until taken, then maybe go idle
  always @(negedge clk) begin : driver
    pin_sample_t nxt;
    if (rst_n && (!in_valid || word_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = sample_q.pop_front();
        in_valid      <= 1'b1;
        in_pin_level  <= nxt.pin;
        in_elapsed_ms <= nxt.dt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("button_press_classifier_unit test failed");
      $finish;
    end
  end

  task automatic add_word(input logic pin, input int dt);
    pin_sample_t s;
    s.pin = pin;
    s.dt  = dt[ELAPSED_W-1:0];
    sample_q.push_back(s);
    added++;
  endtask

  task automatic add_span(input logic pin, input int total, input int step);
    int acc;
    int dt;
    acc = 0;
    do begin
      dt = $urandom_range(step);
      add_word(pin, dt);
      acc += dt;
    end while (acc < total);
  endtask

  // full press: debounce, hold, optional release bounce, release, gap
  task automatic add_press(input int hold_ms, input int gap_ms, input int step,
                           input bit rel_bounce);
    add_word(1'b0, $urandom_range(step));
    add_word(1'b0, $urandom_range(step));
    add_span(1'b0, hold_ms, step);
    if (rel_bounce) begin
      add_word(1'b1, $urandom_range(step));
      add_word(1'b0, $urandom_range(step));
    end
    add_word(1'b1, $urandom_range(step));
    add_word(1'b1, $urandom_range(step));
    add_span(1'b1, gap_ms, step);
  endtask

  task automatic add_random_phase(input int n_words, input int step);
    int top;
    int pick;
    int hold_ms;
    int gap_ms;
    top = int'(long_ms);
    if (int'(mid_ms) > top) top = int'(mid_ms);
    if (int'(max_ms) > top) top = int'(max_ms);
    top = top + top / 4 + 1;
    added = 0;
    while (added < n_words) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        add_word(1'($urandom_range(1)), $urandom_range(255));
      end else if (pick < 20) begin
        add_word(1'b0, $urandom_range(step));
        add_word(1'b1, $urandom_range(step));
      end else begin
        hold_ms = ($urandom_range(99) < 55) ? $urandom_range(long_ms) : $urandom_range(top);
        gap_ms  = ($urandom_range(99) < 70) ? $urandom_range(window_ms)
                                             : int'(window_ms) + $urandom_range(window_ms) + 1;
        add_press(hold_ms, gap_ms, step, $urandom_range(99) < 15);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_idx     <= idx;
    cfg_wr_data <= value[CFG_DAT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int lp, input int mid, input int mx, input int win,
                            input int smax);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_LONG_MID, mid);
    write_reg(REG_LONG_MAX, mx);
    write_reg(REG_REPEAT_WINDOW, win);
    write_reg(REG_SHORT_MAX, smax);
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (sample_q.size() != 0 || in_valid || event_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int lp;
    int mid;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 45;

    // reset values: one short press, then the 500 ms window runs out
    add_word(1'b0, 0);
    add_word(1'b0, 255);
    add_word(1'b1, 10);
    add_word(1'b1, 10);
    add_word(1'b1, 255);
    add_word(1'b1, 255);
    drain();

    set_config(100, 200, 300, 50, 2);
    // bounce while confirming a press
    add_word(1'b0, 0);
    add_word(1'b1, 255);
    // short press, repeat press that bounces (count kept), then a press
    // with a release bounce that ends the run at two
    add_word(1'b0, 7);
    add_word(1'b0, 10);
    add_word(1'b1, 10);
    add_word(1'b1, 10);
    add_word(1'b0, 10);
    add_word(1'b1, 5);
    add_word(1'b0, 3);
    add_word(1'b0, 5);
    add_word(1'b1, 5);
    add_word(1'b0, 5);
    add_word(1'b1, 5);
    add_word(1'b1, 5);
    // long press, longest class
    add_word(1'b0, 0);
    add_word(1'b0, 255);
    add_word(1'b1, 40);
    add_word(1'b1, 10);
    // short press, then a long one inside the run: dropped
    add_word(1'b0, 1);
    add_word(1'b0, 1);
    add_word(1'b1, 1);
    add_word(1'b1, 1);
    add_word(1'b0, 1);
    add_word(1'b0, 200);
    add_word(1'b1, 0);
    add_word(1'b1, 0);
    drain();

    lp = $urandom_range(600, 200);
    mid = lp + $urandom_range(400);
    set_config(lp, mid, mid + $urandom_range(600), $urandom_range(400, 100),
               $urandom_range(4, 1));
    add_random_phase(PHASE_WORDS, 255);
    drain();

    set_config(800, 1200, 1600, 300, 15);
    add_random_phase(PHASE_WORDS, 255);
    drain();

    send_idle_pct = 45;
    recv_idle_pct = 20;
    lp = $urandom_range(900, 300);
    mid = lp + $urandom_range(300);
    set_config(lp, mid, mid + $urandom_range(300), $urandom_range(300, 100), 0);
    add_random_phase(PHASE_WORDS, 255);
    drain();

    // everything zero: every press is long; receiver holds off meanwhile
    set_config(0, 0, 0, 0, 0);
    add_random_phase(PHASE_WORDS, 255);
    hold_go = 1'b1;
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config($urandom_range(1500), $urandom_range(1500), $urandom_range(2000),
               $urandom_range(600), $urandom_range(15));
    add_random_phase(PHASE_WORDS, 255);
    drain();

    set_config($urandom_range(300), $urandom_range(300), $urandom_range(300),
               $urandom_range(100), 1);
    add_random_phase(PHASE_WORDS, 32);
    drain();

    // counter saturation: hold and window both pinned at the top
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15);
    add_word(1'b0, 0);
    add_word(1'b0, 255);
    repeat (257) add_word(1'b0, 255);
    add_word(1'b1, 255);
    add_word(1'b1, 255);
    add_word(1'b0, 1);
    add_word(1'b0, 1);
    add_word(1'b1, 1);
    add_word(1'b1, 1);
    repeat (258) add_word(1'b1, 255);
    drain();

    if (error_count == 0)
      $display("button_press_classifier_unit test passed");
    else
      $display("button_press_classifier_unit test failed");
    $finish;
  end

endmodule
